// ===== rtl/union_find_cycle_detector_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Union-find cycle detector: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_CYCLE_DETECTOR_UNIT_DEFINES_SVH
`define UNION_FIND_CYCLE_DETECTOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define UFCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define UFCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ufcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Union-find cycle detector package
// Sizes, control word layout and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
package ufcd_pkg;

  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned VCNT_W    = 11;
  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(1024);

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_IDLE,
    OP_LOAD_LO,
    OP_LOAD_HI,
    OP_READ,
    OP_STEP,
    OP_SAVE_RLO,
    OP_JOIN,
    OP_CLEAR,
    OP_END_BOOT,
    OP_OUT
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_FIRE,
    C_START,
    C_SKIP,
    C_NOT_ROOT,
    C_CLR_MORE,
    C_BOOT_OR_BUSY
  } cond_e;

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  // Program labels
  localparam step_t ST_IDLE     = 4'd0;
  localparam step_t ST_DISPATCH = 4'd1;
  localparam step_t ST_CHECK    = 4'd2;
  localparam step_t ST_LOAD_LO  = 4'd3;
  localparam step_t ST_RD_LO    = 4'd4;
  localparam step_t ST_WALK_LO  = 4'd5;
  localparam step_t ST_SAVE_RLO = 4'd6;
  localparam step_t ST_LOAD_HI  = 4'd7;
  localparam step_t ST_RD_HI    = 4'd8;
  localparam step_t ST_WALK_HI  = 4'd9;
  localparam step_t ST_JOIN     = 4'd10;
  localparam step_t ST_CLR      = 4'd11;
  localparam step_t ST_CLR_END  = 4'd12;
  localparam step_t ST_OUT      = 4'd13;
  localparam step_t ST_DONE     = 4'd14;

  // Microcode table: taken jump goes to target, else to the next step
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    unique case (step)
      ST_IDLE:     w = '{OP_IDLE,     C_NOT_FIRE,     ST_IDLE};
      ST_DISPATCH: w = '{OP_NONE,     C_START,        ST_CLR};
      ST_CHECK:    w = '{OP_NONE,     C_SKIP,         ST_OUT};
      ST_LOAD_LO:  w = '{OP_LOAD_LO,  C_NEVER,        ST_IDLE};
      ST_RD_LO:    w = '{OP_READ,     C_NEVER,        ST_IDLE};
      ST_WALK_LO:  w = '{OP_STEP,     C_NOT_ROOT,     ST_RD_LO};
      ST_SAVE_RLO: w = '{OP_SAVE_RLO, C_NEVER,        ST_IDLE};
      ST_LOAD_HI:  w = '{OP_LOAD_HI,  C_NEVER,        ST_IDLE};
      ST_RD_HI:    w = '{OP_READ,     C_NEVER,        ST_IDLE};
      ST_WALK_HI:  w = '{OP_STEP,     C_NOT_ROOT,     ST_RD_HI};
      ST_JOIN:     w = '{OP_JOIN,     C_ALWAYS,       ST_OUT};
      ST_CLR:      w = '{OP_CLEAR,    C_CLR_MORE,     ST_CLR};
      ST_CLR_END:  w = '{OP_END_BOOT, C_BOOT_OR_BUSY, ST_IDLE};
      ST_OUT:      w = '{OP_OUT,      C_BOOT_OR_BUSY, ST_OUT};
      ST_DONE:     w = '{OP_NONE,     C_ALWAYS,       ST_IDLE};
      default:     w = '{OP_NONE,     C_ALWAYS,       ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ufcd_item_if.sv =====
// ----------------------------------------------------------------------------
// Union-find cycle detector: input channel
// Valid/ready channel carrying one start or edge transaction.
// ----------------------------------------------------------------------------
interface ufcd_item_if
  import ufcd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, action, node_a, node_b, input ready);
  modport sink   (input valid, action, node_a, node_b, output ready);
endinterface

// ===== rtl/ufcd_result_if.sv =====
// ----------------------------------------------------------------------------
// Union-find cycle detector: result channel
// Valid/ready channel carrying one result transaction per input.
// ----------------------------------------------------------------------------
interface ufcd_result_if;
  logic valid;
  logic ready;
  logic closes_cycle;
  logic cycle_seen;
  logic node_error;

  modport source (output valid, closes_cycle, cycle_seen, node_error, input ready);
  modport sink   (input valid, closes_cycle, cycle_seen, node_error, output ready);
endinterface

// ===== rtl/union_find_cycle_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Union-find cycle detector
// Disjoint-set parent table walked by a microcoded sequencer; flags edges
// that close a cycle in an undirected graph.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  item_i    in   valid/ready          action, node_a, node_b
//  result_o  out  valid/ready          closes_cycle, cycle_seen, node_error
//  cfg       in   cfg_we_i (no wait)   cfg_wdata_i = vertex_count
//
//  One transaction at a time: an edge walks each endpoint to its root (read
//  plus compare per link), then joins the two roots; a skipped edge goes
//  straight to the output step. Start rewrites the whole table, one entry
//  rewritten per cycle; after reset the same pass holds off the input.
//  A waiting result does not block the next input; a stalled result holds
//  the sequencer at its output step.
// ----------------------------------------------------------------------------
`include "union_find_cycle_detector_unit_defines.svh"

module union_find_cycle_detector_unit
  import ufcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [VCNT_W-1:0] cfg_wdata_i,
  ufcd_item_if.sink         item_i,
  ufcd_result_if.source     result_o
);

  // Sequencer state
  step_t             upc_q, upc_d;
  ucode_t            uw;
  logic              jump;
  logic              boot_q;

  // Datapath registers
  logic [VCNT_W-1:0] vcount_q;
  logic              action_q;
  logic [NODE_W-1:0] lo_q, hi_q, cur_q, rlo_q, rdata_q;
  logic [NODE_W-1:0] clr_idx_q;
  logic              err_q, closes_q, cycle_q;

  // Result register
  logic              out_valid_q, out_closes_q, out_seen_q, out_err_q;

  // Table
  logic [NODE_W-1:0] table_mem [MAX_NODES];
  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr, mem_wdata;

  logic              in_fire, out_busy, at_root, in_err;

  assign uw       = ucode_rom(upc_q);
  assign in_fire  = item_i.valid && item_i.ready;
  assign out_busy = out_valid_q && !result_o.ready;
  assign at_root  = (rdata_q == cur_q);
  assign in_err   = (VCNT_W'(item_i.node_a) >= vcount_q) ||
                    (VCNT_W'(item_i.node_b) >= vcount_q);

  assign item_i.ready = (upc_q == ST_IDLE);

  // Evaluate jump condition
  always_comb begin
    unique case (uw.cond)
      C_NEVER:        jump = 1'b0;
      C_ALWAYS:       jump = 1'b1;
      C_NOT_FIRE:     jump = !in_fire;
      C_START:        jump = !action_q;
      C_SKIP:         jump = err_q || (lo_q == hi_q) || cycle_q;
      C_NOT_ROOT:     jump = !at_root;
      C_CLR_MORE:     jump = (clr_idx_q != NODE_W'(MAX_NODES - 1));
      C_BOOT_OR_BUSY: jump = (uw.op == OP_OUT) ? out_busy : boot_q;
      default:        jump = 1'b0;
    endcase
    upc_d = jump ? uw.target : upc_q + step_t'(1);
  end

  // Table write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx_q;
    mem_wdata = clr_idx_q;
    if (uw.op == OP_CLEAR) begin
      mem_we = 1'b1;
    end else if (uw.op == OP_JOIN && rlo_q != cur_q) begin
      mem_we    = 1'b1;
      mem_waddr = rlo_q;
      mem_wdata = cur_q;
    end
  end

  // Table memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (uw.op == OP_READ) begin
      rdata_q <= table_mem[cur_q];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= ST_CLR;
      boot_q      <= 1'b1;
      clr_idx_q   <= '0;
      cycle_q     <= 1'b0;
      vcount_q    <= VCNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      // Advance clear pass and drop the sticky flag
      if (uw.op == OP_CLEAR) begin
        clr_idx_q <= clr_idx_q + NODE_W'(1);
        cycle_q   <= 1'b0;
      end
      if (uw.op == OP_END_BOOT) begin
        boot_q <= 1'b0;
      end
      if (uw.op == OP_JOIN && rlo_q == cur_q) begin
        cycle_q <= 1'b1;
      end
      // Hold result until taken
      if (uw.op == OP_OUT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      OP_IDLE: begin
        if (in_fire) begin
          action_q <= item_i.action;
          // a start transaction never reports a node error
          err_q    <= item_i.action && in_err;
          closes_q <= 1'b0;
          if (item_i.node_a < item_i.node_b) begin
            lo_q <= item_i.node_a;
            hi_q <= item_i.node_b;
          end else begin
            lo_q <= item_i.node_b;
            hi_q <= item_i.node_a;
          end
        end
      end
      OP_LOAD_LO:  cur_q <= lo_q;
      OP_LOAD_HI:  cur_q <= hi_q;
      OP_STEP: begin
        if (!at_root) begin
          cur_q <= rdata_q;
        end
      end
      OP_SAVE_RLO: rlo_q <= cur_q;
      OP_JOIN: begin
        if (rlo_q == cur_q) begin
          closes_q <= 1'b1;
        end
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_closes_q <= closes_q;
          out_seen_q   <= cycle_q;
          out_err_q    <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.closes_cycle = out_closes_q;
  assign result_o.cycle_seen   = out_seen_q;
  assign result_o.node_error   = out_err_q;

  // Checks
  `UFCD_ASSERT_NEXT(a_fire_dispatch, clk_i, rst_ni, in_fire, upc_q == ST_DISPATCH,
    "accepted transaction did not reach dispatch")
  `UFCD_ASSERT_SAME(a_clr_idx_idle, clk_i, rst_ni, clr_idx_q != '0, upc_q == ST_CLR,
    "clear index moved outside the clear pass")
  `UFCD_ASSERT_SAME(a_closes_sets_flag, clk_i, rst_ni,
    (uw.op == OP_OUT) && !out_busy && closes_q, cycle_q,
    "cycle reported without the sticky flag")

endmodule
